>>> src/tdl_pkg.sv
// shared types, constants and helpers for the time-of-day pixel lighting block
// no dependencies; every other file except tdl_checker uses this package
package tdl_pkg;

  localparam int ROW_BITS   = 12;
  localparam int FRAC_BITS  = 8;
  localparam int HOUR_W     = 13;
  localparam int CH_W       = 8;
  localparam int BR_W       = 9;
  localparam int Q8_ONE     = 256;
  localparam int T_ONE      = 1 << FRAC_BITS;
  localparam int MIX_W      = CH_W + FRAC_BITS + 1;
  localparam int NUM_W      = CH_W + ROW_BITS;
  localparam int DIV_STAGES = CH_W;
  localparam int CMD_W      = 2;
  localparam int EXTRA_W    = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = HOUR_W;

  // command codes
  localparam logic [CMD_W-1:0] CMD_SCALE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TINT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SKY    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOUR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

  localparam logic [ROW_BITS-1:0] ROWS_RESET = ROW_BITS'(480);

  typedef logic [CH_W-1:0] ch_t;

  typedef struct packed {
    ch_t r;
    ch_t g;
    ch_t b;
  } rgb_t;

  // lighting state derived from the registers
  typedef struct packed {
    rgb_t                top;
    rgb_t                bot;
    logic [BR_W-1:0]     amb;
    logic                lit;
    logic [ROW_BITS-1:0] hgt;
  } light_t;

  // one divider pipeline stage
  typedef struct packed {
    logic                sky;
    logic                lit;
    rgb_t                res;
    logic [ROW_BITS-1:0] d;
    logic [NUM_W-1:0]    nr;
    logic [NUM_W-1:0]    ng;
    logic [NUM_W-1:0]    nb;
    ch_t                 qr;
    ch_t                 qg;
    ch_t                 qb;
  } div_t;

  // linear blend of two channels by weight t
  function automatic ch_t mix_ch(ch_t a, ch_t b, logic [FRAC_BITS-1:0] t);
    logic [MIX_W-1:0] s;
    s = MIX_W'(a) * (MIX_W'(T_ONE) - MIX_W'(t)) + MIX_W'(b) * MIX_W'(t);
    return s[FRAC_BITS +: CH_W];
  endfunction

endpackage

>>> src/tdl_if.sv
// valid/ready channel interfaces for input and result transactions
// depends on tdl_pkg
interface tdl_in_if;
  logic                         valid;
  logic                         ready;
  logic [tdl_pkg::CMD_W-1:0]    cmd;
  logic [23:0]                  pixel_rgb;
  logic [tdl_pkg::EXTRA_W-1:0]  extra_bright_q8;
  logic [tdl_pkg::ROW_BITS-1:0] row;
  modport source (output valid, cmd, pixel_rgb, extra_bright_q8, row, input ready);
  modport sink   (input valid, cmd, pixel_rgb, extra_bright_q8, row, output ready);
endinterface

interface tdl_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] rgb_out;
  logic        lamps_lit;
  modport source (output valid, rgb_out, lamps_lit, input ready);
  modport sink   (input valid, rgb_out, lamps_lit, output ready);
endinterface

>>> src/tdl_cfg.sv
// configuration registers and the lighting values derived from the hour
// depends on tdl_pkg
module tdl_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tdl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tdl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output tdl_pkg::light_t                 light
);
  import tdl_pkg::*;

  localparam logic [HOUR_W-1:0] H5  = HOUR_W'(5 * 256);
  localparam logic [HOUR_W-1:0] H6  = HOUR_W'(6 * 256);
  localparam logic [HOUR_W-1:0] H7  = HOUR_W'(7 * 256);
  localparam logic [HOUR_W-1:0] H17 = HOUR_W'(17 * 256);
  localparam logic [HOUR_W-1:0] H18 = HOUR_W'(18 * 256);
  localparam logic [HOUR_W-1:0] H19 = HOUR_W'(19 * 256);

  logic [HOUR_W-1:0]        hour_r;
  logic [ROW_BITS-1:0]      rows_r;
  light_t                   light_r;
  light_t                   light_nxt;
  logic [HOUR_W-1:0]        d_rise;
  logic [HOUR_W-1:0]        d_set;
  logic [FRAC_BITS+8:0]     tw_rise;
  logic [FRAC_BITS+8:0]     tw_set;
  logic [FRAC_BITS-1:0]     t_rise;
  logic [FRAC_BITS-1:0]     t_set;
  logic [15:0]              amb_up;
  logic [15:0]              amb_dn;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r <= '0;
      rows_r <= ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOUR: hour_r <= cfg_wdata[HOUR_W-1:0];
        CFG_ROWS: rows_r <= cfg_wdata[ROW_BITS-1:0];
        default:  hour_r <= hour_r;
      endcase
    end
  end

  // blend weights over the two-hour sunrise and sunset windows
  always_comb begin
    d_rise  = hour_r - H5;
    d_set   = hour_r - H17;
    tw_rise = {d_rise[8:0], {FRAC_BITS{1'b0}}};
    tw_set  = {d_set[8:0], {FRAC_BITS{1'b0}}};
    t_rise  = tw_rise[FRAC_BITS+8:9];
    t_set   = tw_set[FRAC_BITS+8:9];
    amb_up  = 16'(d_rise[7:0] - 8'd0) * 16'd179;
    amb_dn  = 16'(d_set[7:0]) * 16'd154;
  end

  // sky colors, ambient and lamps from the hour
  always_comb begin
    light_nxt     = '0;
    light_nxt.hgt = (rows_r == '0) ? ROW_BITS'(1) : rows_r;
    light_nxt.lit = (hour_r < H6) || (hour_r >= H18);
    priority if (hour_r >= H5 && hour_r < H7) begin
      light_nxt.top = '{mix_ch(8'd255, 8'd135, t_rise), mix_ch(8'd140, 8'd206, t_rise),
                        mix_ch(8'd100, 8'd235, t_rise)};
      light_nxt.bot = '{mix_ch(8'd255, 8'd135, t_rise), mix_ch(8'd200, 8'd215, t_rise),
                        mix_ch(8'd150, 8'd255, t_rise)};
    end else if (hour_r >= H7 && hour_r < H17) begin
      light_nxt.top = '{8'd135, 8'd206, 8'd235};
      light_nxt.bot = '{8'd135, 8'd215, 8'd255};
    end else if (hour_r >= H17 && hour_r < H19) begin
      light_nxt.top = '{mix_ch(8'd135, 8'd25, t_set), mix_ch(8'd206, 8'd25, t_set),
                        mix_ch(8'd235, 8'd112, t_set)};
      light_nxt.bot = '{mix_ch(8'd135, 8'd255, t_set), mix_ch(8'd215, 8'd140, t_set),
                        mix_ch(8'd255, 8'd50, t_set)};
    end else begin
      light_nxt.top = '{8'd25, 8'd25, 8'd112};
      light_nxt.bot = '{8'd15, 8'd15, 8'd60};
    end
    priority if (hour_r >= H7 && hour_r < H17) begin
      light_nxt.amb = BR_W'(Q8_ONE);
    end else if (hour_r >= H6 && hour_r < H7) begin
      light_nxt.amb = BR_W'(77) + BR_W'(amb_up[15:8]);
    end else if (hour_r >= H17 && hour_r < H18) begin
      light_nxt.amb = BR_W'(Q8_ONE) - BR_W'(amb_dn[15:8]);
    end else begin
      light_nxt.amb = BR_W'(102);
    end
  end

  // derived values refreshed every cycle
  always_ff @(posedge clk) begin
    light_r <= light_nxt;
  end

  assign light = light_r;

endmodule

>>> src/tdl_front.sv
// front pipeline: input register, tint and clamp stage, multiply stage
// depends on tdl_pkg
module tdl_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_v,
  input  logic [tdl_pkg::CMD_W-1:0]      in_cmd,
  input  logic [23:0]                    in_rgb,
  input  logic [tdl_pkg::EXTRA_W-1:0]    in_extra,
  input  logic [tdl_pkg::ROW_BITS-1:0]   in_row,
  input  tdl_pkg::light_t                light,
  output logic                           out_v,
  output tdl_pkg::div_t                  out_d
);
  import tdl_pkg::*;

  logic                  s1_v_r;
  logic [CMD_W-1:0]      s1_cmd_r;
  rgb_t                  s1_rgb_r;
  logic [EXTRA_W-1:0]    s1_extra_r;
  logic [ROW_BITS-1:0]   s1_row_r;

  logic                  s2_v_r;
  logic [CMD_W-1:0]      s2_cmd_r;
  rgb_t                  s2_rgb_r;
  logic [BR_W-1:0]       s2_br_r;
  logic [ROW_BITS-1:0]   s2_y_r;
  logic [ROW_BITS-1:0]   s2_hm_r;

  logic                  s3_v_r;
  div_t                  s3_r;

  rgb_t                  rgb_nxt;
  logic [BR_W-1:0]       br_nxt;
  logic [ROW_BITS-1:0]   y_nxt;
  logic [BR_W:0]         br_sum;
  logic [15:0]           red_t;
  logic [16:0]           blue_t;
  div_t                  d_nxt;
  logic [16:0]           sc_r;
  logic [16:0]           sc_g;
  logic [16:0]           sc_b;

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd_r   <= in_cmd;
      s1_rgb_r   <= in_rgb;
      s1_extra_r <= in_extra;
      s1_row_r   <= in_row;
    end
  end

  // night tint, brightness clamp and row clamp
  always_comb begin
    red_t   = 16'(s1_rgb_r.r) * 16'd179;
    blue_t  = 17'(s1_rgb_r.b) * 17'd282;
    rgb_nxt = s1_rgb_r;
    if (s1_cmd_r == CMD_TINT && light.lit) begin
      rgb_nxt.r = red_t[15:8];
      rgb_nxt.b = blue_t[16] ? 8'd255 : blue_t[15:8];
    end
    br_sum = (BR_W+1)'(light.amb) + (BR_W+1)'(s1_extra_r);
    if (s1_cmd_r == CMD_TINT) begin
      br_nxt = light.amb;
    end else begin
      br_nxt = (br_sum > (BR_W+1)'(Q8_ONE)) ? BR_W'(Q8_ONE) : br_sum[BR_W-1:0];
    end
    y_nxt = (s1_row_r > light.hgt) ? light.hgt : s1_row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_cmd_r <= s1_cmd_r;
      s2_rgb_r <= rgb_nxt;
      s2_br_r  <= br_nxt;
      s2_y_r   <= y_nxt;
      s2_hm_r  <= light.hgt - y_nxt;
    end
  end

  // brightness products and sky gradient numerators
  always_comb begin
    sc_r        = 17'(s2_rgb_r.r) * 17'(s2_br_r);
    sc_g        = 17'(s2_rgb_r.g) * 17'(s2_br_r);
    sc_b        = 17'(s2_rgb_r.b) * 17'(s2_br_r);
    d_nxt       = '0;
    d_nxt.lit   = light.lit;
    d_nxt.d     = light.hgt;
    d_nxt.sky   = (s2_cmd_r == CMD_SKY);
    d_nxt.nr    = NUM_W'(light.top.r) * NUM_W'(s2_hm_r) + NUM_W'(light.bot.r) * NUM_W'(s2_y_r);
    d_nxt.ng    = NUM_W'(light.top.g) * NUM_W'(s2_hm_r) + NUM_W'(light.bot.g) * NUM_W'(s2_y_r);
    d_nxt.nb    = NUM_W'(light.top.b) * NUM_W'(s2_hm_r) + NUM_W'(light.bot.b) * NUM_W'(s2_y_r);
    if (s2_cmd_r == CMD_SCALE || s2_cmd_r == CMD_TINT) begin
      d_nxt.res = '{sc_r[15:8], sc_g[15:8], sc_b[15:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= d_nxt;
    end
  end

  assign out_v = s3_v_r;
  assign out_d = s3_r;

endmodule

>>> src/tdl_div.sv
// restoring divider pipeline, one quotient bit per stage for each channel
// depends on tdl_pkg
module tdl_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  tdl_pkg::div_t   in_d,
  output logic            out_v,
  output tdl_pkg::div_t   out_d
);
  import tdl_pkg::*;

  logic v_r  [DIV_STAGES];
  div_t st_r [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    localparam int K = DIV_STAGES - 1 - i;
    div_t             src;
    logic             src_v;
    div_t             st_nxt;
    logic [NUM_W-1:0] dsh;

    if (i == 0) begin : g_first
      assign src   = in_d;
      assign src_v = in_v;
    end else begin : g_next
      assign src   = st_r[i-1];
      assign src_v = v_r[i-1];
    end

    // compare and subtract the shifted divisor for this quotient bit
    always_comb begin
      dsh    = NUM_W'(src.d) << K;
      st_nxt = src;
      if (src.nr >= dsh) begin
        st_nxt.nr    = src.nr - dsh;
        st_nxt.qr[K] = 1'b1;
      end
      if (src.ng >= dsh) begin
        st_nxt.ng    = src.ng - dsh;
        st_nxt.qg[K] = 1'b1;
      end
      if (src.nb >= dsh) begin
        st_nxt.nb    = src.nb - dsh;
        st_nxt.qb[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i] <= st_nxt;
      end
    end
  end

  assign out_v = v_r[DIV_STAGES-1];
  assign out_d = st_r[DIV_STAGES-1];

endmodule

>>> src/time_of_day_pixel_lighting_top.sv
// Time-of-day pixel lighting. One transaction is accepted every clock while the result
// side takes results; each result passes through 3 front stages (input, tint/clamp,
// multiply) and then 8 divider stages, one quotient bit each for the sky gradient, before
// it is offered. The whole pipeline holds when out is stalled, and in.ready is high
// whenever the last stage is empty or being taken. Derived lighting values are registered
// from the configuration registers. Commands: 0 brightness scale, 1 night tint then
// scale, 2 sky gradient color for a row, 3 returns black.
// depends on tdl_pkg, tdl_if, tdl_cfg, tdl_front, tdl_div
module time_of_day_pixel_lighting_top (
  input  logic                           clk,
  input  logic                           rst_n,
  tdl_in_if.sink                         in_ch,
  tdl_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tdl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tdl_pkg::*;

  light_t light;
  logic   en;
  logic   f_v;
  div_t   f_d;
  logic   q_v;
  div_t   q_d;

  // global advance: last stage empty or taken
  assign en          = !q_v || out_ch.ready;
  assign in_ch.ready = en;

  tdl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .light     (light)
  );

  tdl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_rgb   (in_ch.pixel_rgb),
    .in_extra (in_ch.extra_bright_q8),
    .in_row   (in_ch.row),
    .light    (light),
    .out_v    (f_v),
    .out_d    (f_d)
  );

  tdl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (f_v),
    .in_d  (f_d),
    .out_v (q_v),
    .out_d (q_d)
  );

  // result selection
  assign out_ch.valid     = q_v;
  assign out_ch.rgb_out   = q_d.sky ? {q_d.qr, q_d.qg, q_d.qb} : q_d.res;
  assign out_ch.lamps_lit = q_d.lit;

endmodule

>>> src/tdl_checker.sv
// port-level checks for the time-of-day pixel lighting block
// depends on time_of_day_pixel_lighting_top; attached by bind
module tdl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_rgb,
  input logic        out_lit
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_rgb) && $stable(out_lit))
    else $error("result changed while stalled");

  // input side only stalls when a result is blocked
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output side");

  // pipeline empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind time_of_day_pixel_lighting_top tdl_checker u_tdl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_rgb   (out_ch.rgb_out),
  .out_lit   (out_ch.lamps_lit)
);
